[hdl/lzss_decompressor_defines.svh]
// ----------------------------------------------------------------------------
// LZSS decompressor assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LZSS_DECOMPRESSOR_DEFINES_SVH
`define LZSS_DECOMPRESSOR_DEFINES_SVH

// expression holds at every clock edge out of reset
`define LZD_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define LZD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lzd_pkg.sv]
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Window geometry, register map and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package lzd_pkg;

   localparam int WIN_BYTES = 4096;
   localparam int WIN_AW    = $clog2(WIN_BYTES);
   localparam int FILL_W    = WIN_AW + 1;
   localparam int REM_W     = 5;

   localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(12'hFEE);
   localparam logic [REM_W-1:0]  MIN_MATCH = REM_W'(3);

   // configuration register map
   localparam int  CSR_AW         = 3;
   localparam logic REG_OUT_LENGTH = 1'b0;
   localparam logic [31:0] OUT_LENGTH_RESET = 32'd1;

   typedef struct packed {
      logic load_flags;
      logic take_offset;
      logic start_match;
      logic emit_literal;
      logic emit_match;
      logic read_next;
   } cmd_type;

   typedef struct packed {
      logic ctl_bit;
      logic bits_left_zero;
      logic more_bytes;
      logic out_done;
   } status_type;

endpackage

[hdl/lzss_decompressor.sv]
// A literal item gives its result in the cycle after it is accepted; a flag or
// offset-low item gives none and the next item can be taken in the cycle after.
// A match reads each byte from the window, then presents it in the output state
// and moves on only once rsp_ready is high; no new item is taken meanwhile.
// Reset is synchronous; the window reads as zero until written, with no clear pass.
// ----------------------------------------------------------------------------
// LZSS decompressor, 4 KiB window
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module lzss_decompressor (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_in_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_run_last,
   output logic                      rsp_done_res,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [lzd_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   import lzd_pkg::*;

   logic        csr_wr;
   logic        csr_sel_len;
   logic [31:0] out_length_ff;
   cmd_type     cmd;
   status_type  sts;

   assign pready      = 1'b1;
   assign csr_sel_len = (paddr[CSR_AW-1:2] == REG_OUT_LENGTH);
   assign csr_wr      = psel && penable && pwrite && pready;
   assign prdata      = csr_sel_len ? out_length_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_length_ff <= OUT_LENGTH_RESET;
      end else if (csr_wr && csr_sel_len) begin
         out_length_ff <= pwdata;
      end
   end

   lzd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lzd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_byte    (req_in_byte),
      .out_length (out_length_ff),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_run_last),
      .out_done   (rsp_done_res)
   );

endmodule

[hdl/lzd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lzd_ctrl.sv]
// ----------------------------------------------------------------------------
// LZSS decompressor controller
// Sequences flag, literal and match bytes and the output handshake.
// ----------------------------------------------------------------------------
module lzd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lzd_pkg::status_type sts,
   output lzd_pkg::cmd_type    cmd
);

   import lzd_pkg::*;

   `include "lzss_decompressor_defines.svh"

   localparam logic [2:0] ST_FLAG = 3'd0;
   localparam logic [2:0] ST_DATA = 3'd1;
   localparam logic [2:0] ST_HIGH = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;
   localparam logic [2:0] ST_STOP = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       req_acc;

   assign req_ready = state_ff inside {ST_FLAG, ST_DATA, ST_HIGH, ST_STOP};
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_acc   = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_FLAG: begin
            if (req_acc) begin
               cmd.load_flags = 1'b1;
               state_in       = ST_DATA;
            end
         end
         ST_DATA: begin
            if (req_acc) begin
               if (sts.ctl_bit) begin
                  cmd.emit_literal = 1'b1;
                  state_in         = ST_OUT;
               end else begin
                  cmd.take_offset = 1'b1;
                  state_in        = ST_HIGH;
               end
            end
         end
         ST_HIGH: begin
            if (req_acc) begin
               cmd.start_match = 1'b1;
               state_in        = ST_READ;
            end
         end
         ST_READ: begin
            cmd.emit_match = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (sts.out_done) begin
                  state_in = ST_STOP;
               end else if (sts.more_bytes) begin
                  cmd.read_next = 1'b1;
                  state_in      = ST_READ;
               end else if (sts.bits_left_zero) begin
                  state_in = ST_FLAG;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_STOP: begin
            // drop every later item
            state_in = ST_STOP;
         end
         default: begin
            state_in = ST_FLAG;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FLAG;
      end else begin
         state_ff <= state_in;
      end
   end

   `LZD_ASSERT_NEXT(a_stop_sticky, state_ff == ST_STOP, state_ff == ST_STOP,
      "output restarted after the length was reached")
   `LZD_ASSERT_NEXT(a_read_then_out, state_ff == ST_READ, state_ff == ST_OUT,
      "match byte not presented after its window read")

endmodule

[hdl/lzd_dp.sv]
// ----------------------------------------------------------------------------
// LZSS decompressor datapath
// History window, flag shifter, match counters and the output register.
// ----------------------------------------------------------------------------
module lzd_dp (
   input  logic                clock,
   input  logic                reset,
   input  lzd_pkg::cmd_type    cmd,
   output lzd_pkg::status_type sts,
   input  logic [7:0]          in_byte,
   input  logic [31:0]         out_length,
   output logic [7:0]          out_byte,
   output logic                out_last,
   output logic                out_done
);

   import lzd_pkg::*;

   `include "lzss_decompressor_defines.svh"

   logic [7:0]        flags_ff, flags_in;
   logic [3:0]        left_ff, left_in;
   logic [7:0]        off_low_ff, off_low_in;
   logic [WIN_AW-1:0] addr_ff, addr_in;
   logic [REM_W-1:0]  remain_ff, remain_in;
   logic [WIN_AW-1:0] wpos_ff, wpos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       count_ff, count_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_done_ff, out_done_in;
   logic              rd_ok_ff;

   logic              use_bit;
   logic              emit;
   logic [7:0]        emit_byte;
   logic [31:0]       count_next;
   logic              hit_done;
   logic              rd_en;
   logic [WIN_AW-1:0] rd_addr;
   logic [WIN_AW-1:0] rd_rel;
   logic              rd_ok_in;
   logic [7:0]        ram_q;
   logic              wr_en;

   assign use_bit    = cmd.emit_literal || cmd.start_match;
   assign emit       = cmd.emit_literal || cmd.emit_match;
   // a window entry never written since reset reads as zero
   assign emit_byte  = cmd.emit_literal ? in_byte : (rd_ok_ff ? ram_q : 8'h00);
   assign count_next = count_ff + 32'd1;
   assign hit_done   = (count_next >= out_length);
   assign wr_en      = emit && !hit_done;

   assign rd_en   = cmd.start_match || cmd.read_next;
   assign rd_addr = cmd.start_match ? {in_byte[7:4], off_low_ff} : addr_ff;
   // written entries form one run starting at the initial write position
   assign rd_rel   = rd_addr - START_POS;
   assign rd_ok_in = ({1'b0, rd_rel} < fill_ff);

   always_comb begin
      flags_in    = flags_ff;
      left_in     = left_ff;
      off_low_in  = off_low_ff;
      addr_in     = addr_ff;
      remain_in   = remain_ff;
      wpos_in     = wpos_ff;
      fill_in     = fill_ff;
      count_in    = count_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_done_in = out_done_ff;

      if (cmd.load_flags) begin
         flags_in = in_byte;
         left_in  = 4'd8;
      end
      if (use_bit) begin
         flags_in = {1'b0, flags_ff[7:1]};
         if (left_ff != 4'd0) begin
            left_in = left_ff - 4'd1;
         end
      end
      if (cmd.take_offset) begin
         off_low_in = in_byte;
      end
      if (cmd.start_match) begin
         remain_in = {1'b0, in_byte[3:0]} + MIN_MATCH;
         addr_in   = rd_addr + WIN_AW'(1);
      end
      if (cmd.read_next) begin
         addr_in = addr_ff + WIN_AW'(1);
      end
      if (emit) begin
         count_in    = count_next;
         out_byte_in = emit_byte;
         out_done_in = hit_done;
         out_last_in = cmd.emit_literal || (remain_ff == REM_W'(1)) || hit_done;
         if (cmd.emit_match) begin
            remain_in = remain_ff - REM_W'(1);
         end
      end
      if (wr_en) begin
         wpos_in = wpos_ff + WIN_AW'(1);
         if (fill_ff != FILL_W'(WIN_BYTES)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= '0;
         left_ff     <= '0;
         remain_ff   <= '0;
         wpos_ff     <= START_POS;
         fill_ff     <= '0;
         count_ff    <= '0;
         out_done_ff <= 1'b0;
      end else begin
         flags_ff    <= flags_in;
         left_ff     <= left_in;
         remain_ff   <= remain_in;
         wpos_ff     <= wpos_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         out_done_ff <= out_done_in;
      end
   end

   always_ff @(posedge clock) begin
      off_low_ff  <= off_low_in;
      addr_ff     <= addr_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      if (rd_en) begin
         rd_ok_ff <= rd_ok_in;
      end
   end

   lzd_ram #(
      .WIDTH (8),
      .DEPTH (WIN_BYTES)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wpos_ff),
      .wr_data (emit_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign sts.ctl_bit        = flags_ff[0];
   assign sts.bits_left_zero = (left_ff == 4'd0);
   assign sts.more_bytes     = (remain_ff != '0);
   assign sts.out_done       = out_done_ff;

   assign out_byte = out_byte_ff;
   assign out_last = out_last_ff;
   assign out_done = out_done_ff;

   `LZD_ASSERT_ALWAYS(a_fill_bound, fill_ff <= FILL_W'(WIN_BYTES),
      "window fill count beyond window size")
   `LZD_ASSERT_ALWAYS(a_remain_bound, remain_ff <= MIN_MATCH + REM_W'(15),
      "match byte count beyond longest match")
   `LZD_ASSERT_NEXT(a_write_tracks_fill, wr_en && (fill_ff != FILL_W'(WIN_BYTES)),
      fill_ff == $past(fill_ff) + FILL_W'(1), "window write not counted in fill")

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZSS decompressor testbench
// Feeds a compressed byte stream through the request channel and checks every
// decompressed byte against an in-bench decoder, or against fixed values on
// some directed rows. A short directed table opens the run. Random flag groups
// with mostly near-distance matches follow, across several output-length
// settings. The last setting ends the stream and proves that later bytes are dropped.
// ----------------------------------------------------------------------------
module tb;
   import lzd_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       done_res;
   } rsp_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic [4:0] n_fixed;
      logic [7:0] fixed_out;
   } dir_row_type;

   typedef enum logic [1:0] {DEC_FLAG, DEC_DATA, DEC_MATCH} dec_phase_type;

   localparam logic [CSR_AW-1:0] OUT_LENGTH_ADDR = {REG_OUT_LENGTH, 2'b00};
   localparam int N_DIR = 24;

   // flag 0x06: match, two literals, five matches; then flag 0xFF and 8 literals
   localparam dir_row_type DIR_TAB [N_DIR] = '{
      '{8'h06, 5'd0, 8'h00},
      '{8'h00, 5'd0, 8'h00}, '{8'h00, 5'd3, 8'h00},
      '{8'hFF, 5'd1, 8'hFF}, '{8'h00, 5'd1, 8'h00},
      '{8'hEE, 5'd0, 8'h00}, '{8'hFF, 5'd0, 8'h00},
      '{8'hFF, 5'd0, 8'h00}, '{8'hF0, 5'd0, 8'h00},
      '{8'h34, 5'd0, 8'h00}, '{8'h12, 5'd0, 8'h00},
      '{8'hAA, 5'd0, 8'h00}, '{8'h55, 5'd0, 8'h00},
      '{8'h01, 5'd0, 8'h00}, '{8'h0F, 5'd0, 8'h00},
      '{8'hFF, 5'd0, 8'h00},
      '{8'h00, 5'd1, 8'h00}, '{8'hFF, 5'd1, 8'hFF},
      '{8'h80, 5'd1, 8'h80}, '{8'h01, 5'd1, 8'h01},
      '{8'h7F, 5'd1, 8'h7F}, '{8'h55, 5'd1, 8'h55},
      '{8'hAA, 5'd1, 8'hAA}, '{8'h5A, 5'd1, 8'h5A}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [7:0]          req_in_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [7:0]          rsp_out_byte;
   logic                rsp_run_last;
   logic                rsp_done_res;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   // decoder state
   logic [7:0]          win_mem [WIN_BYTES];
   logic [WIN_AW-1:0]   wr_pos;
   logic [7:0]          flag_bits;
   logic [3:0]          flags_left;
   dec_phase_type       dec_ph;
   logic [7:0]          match_lo;
   logic [31:0]         byte_count;
   logic                stream_done;
   logic [31:0]         cfg_out_length;

   rsp_type             step_out [$];
   rsp_type             expected_bytes [$];
   int                  fail_count;
   int                  sent_items;
   bit                  send_calm;
   bit                  held_once;

   lzss_decompressor dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_done_res (rsp_done_res),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("lzss_decompressor test failed");
      $finish;
   end

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // emit one byte; returns 1 when the output length is reached
   function automatic bit put_byte(input logic [7:0] d);
      rsp_type r;
      byte_count = byte_count + 32'd1;
      r.out_byte = d;
      r.run_last = 1'b0;
      r.done_res = (byte_count >= cfg_out_length);
      step_out.push_back(r);
      if (r.done_res) begin
         stream_done = 1'b1;
         return 1'b1;
      end
      win_mem[wr_pos] = d;
      wr_pos = wr_pos + 1'b1;
      return 1'b0;
   endfunction

   function automatic void use_flag();
      flag_bits = flag_bits >> 1;
      if (flags_left != 4'd0) flags_left = flags_left - 4'd1;
      dec_ph = (flags_left != 4'd0) ? DEC_DATA : DEC_FLAG;
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      logic [WIN_AW-1:0] off;
      int len;
      step_out.delete();
      if (stream_done) return;
      case (dec_ph)
         DEC_DATA: begin
            if (flag_bits[0]) begin
               use_flag();
               void'(put_byte(b));
            end else begin
               match_lo = b;
               dec_ph = DEC_MATCH;
            end
         end
         DEC_MATCH: begin
            off = {b[7:4], match_lo};
            len = int'(b[3:0]) + int'(MIN_MATCH);
            use_flag();
            for (int i = 0; i < len; i++) begin
               if (put_byte(win_mem[off + WIN_AW'(i)])) break;
            end
         end
         default: begin
            flag_bits = b;
            flags_left = 4'd8;
            dec_ph = DEC_DATA;
         end
      endcase
      if (step_out.size() > 0) step_out[step_out.size()-1].run_last = 1'b1;
   endfunction

   // offer one item, hold until accepted, then queue what it produces
   task automatic push_byte(input logic [7:0] b, input int n_fixed,
                            input logic [7:0] fixed_out);
      rsp_type r;
      int g;
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      decode_byte(b);
      if (n_fixed > 0) begin
         for (int k = 0; k < n_fixed; k++) begin
            r.out_byte = fixed_out;
            r.run_last = (k == n_fixed - 1);
            r.done_res = 1'b0;
            expected_bytes.push_back(r);
         end
      end else begin
         foreach (step_out[k]) expected_bytes.push_back(step_out[k]);
      end
      g = pick_gap(send_calm);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_group();
      logic [7:0] flags;
      logic [WIN_AW-1:0] off;
      flags = 8'($urandom_range(0, 255));
      push_byte(flags, 0, 8'h00);
      for (int k = 0; k < 8; k++) begin
         if (flags[k]) begin
            push_byte(8'($urandom_range(0, 255)), 0, 8'h00);
         end else begin
            if ($urandom_range(0, 9) < 7)
               off = wr_pos - WIN_AW'($urandom_range(1, 40));
            else
               off = WIN_AW'($urandom_range(0, WIN_BYTES - 1));
            push_byte(off[7:0], 0, 8'h00);
            push_byte({off[11:8], 4'($urandom_range(0, 15))}, 0, 8'h00);
         end
      end
      // noise: stray bytes, then realign on a flag byte
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)), 0, 8'h00);
         while (dec_ph != DEC_FLAG) push_byte(8'($urandom_range(0, 255)), 0, 8'h00);
      end
   endtask

   // drop the request and let every queued result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= OUT_LENGTH_ADDR;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      cfg_out_length = v;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      // read back
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== v) begin
         $error("out_length readback: expected %h, actual %h", v, prdata);
         fail_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // result side
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte %h", rsp_out_byte);
            fail_count++;
         end else begin
            e = expected_bytes.pop_front();
            if (rsp_out_byte !== e.out_byte) begin
               $error("out_byte: expected %h, actual %h", e.out_byte, rsp_out_byte);
               fail_count++;
            end
            if (rsp_run_last !== e.run_last) begin
               $error("run_last: expected %b, actual %b", e.run_last, rsp_run_last);
               fail_count++;
            end
            if (rsp_done_res !== e.done_res) begin
               $error("done_res: expected %b, actual %b", e.done_res, rsp_done_res);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int g;
      rsp_ready = 1'b0;
      held_once = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_once && sent_items >= 80) begin
            // long hold-off so the block backs up and stalls its input
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            held_once = 1'b1;
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         g = pick_gap(1'b0);
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

   initial begin
      int target;
      logic [31:0] len_set;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = 32'd0;
      fail_count = 0;
      sent_items = 0;
      send_calm = 1'b0;
      foreach (win_mem[i]) win_mem[i] = 8'h00;
      wr_pos = START_POS;
      flag_bits = 8'h00;
      flags_left = 4'd0;
      dec_ph = DEC_FLAG;
      match_lo = 8'h00;
      byte_count = 32'd0;
      stream_done = 1'b0;
      cfg_out_length = OUT_LENGTH_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(32'hFFFF_FFFF);
      for (int i = 0; i < N_DIR; i++)
         push_byte(DIR_TAB[i].in_byte, int'(DIR_TAB[i].n_fixed), DIR_TAB[i].fixed_out);

      target = sent_items;
      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         case (ph)
            0: len_set = byte_count + 32'($urandom_range(5000, 1000000));
            1: len_set = 32'h8000_0000;
            2: len_set = 32'hFFFF_FFFF;
            default: len_set = byte_count + 32'($urandom_range(5000, 100000));
         endcase
         csr_write(len_set);
         send_calm = (ph == 2);
         target += 120;
         while (sent_items < target) send_group();
      end

      // lower the length below the count: the first byte of the match ends it
      wait_idle();
      send_calm = 1'b0;
      csr_write(32'd1);
      csr_write(32'd0);
      push_byte(8'h00, 0, 8'h00);
      push_byte(8'h12, 0, 8'h00);
      push_byte(8'h3F, 0, 8'h00);
      // everything after the end is dropped
      repeat (20) push_byte(8'($urandom_range(0, 255)), 0, 8'h00);

      wait_idle();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("lzss_decompressor test passed");
      else
         $display("lzss_decompressor test failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/lzd_pkg.sv
hdl/lzd_ram.sv
hdl/lzd_ctrl.sv
hdl/lzd_dp.sv
hdl/lzss_decompressor.sv
dv/tb.sv
